// ===== hw/rtl/fxalu_pkg.sv =====
// Shared types and opcodes for the Q24.8 fixed-point ALU.
// No dependencies.
package fxalu_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]   cmd;
		logic [31:0]  operand_a;
		logic [31:0]  operand_b;
	} in_word_t;

	typedef struct packed {
		logic [31:0]  value;
		logic         flag;
		logic         div_zero;
	} out_word_t;

	// Operation class decided in the front end
	typedef enum logic [1:0] {
		CL_SIMPLE = 2'd0,
		CL_MUL = 2'd1,
		CL_DIV = 2'd2
	} class_t;

	typedef struct packed {
		class_t       cls;
		logic [31:0]  value;
		logic         flag;
		logic         div_zero;
		logic [31:0]  operand_a;
		logic [31:0]  operand_b;
	} job_t;

endpackage

// ===== hw/rtl/fxalu_front.sv =====
// Front end: decodes each word, computes the simple ops combinationally and classifies.
// Depends on fxalu_pkg.
module fxalu_front #(
	parameter int FRAC_BITS = 8
) (
	input  fxalu_pkg::in_word_t  in_word,
	output fxalu_pkg::job_t      job
);

	logic signed [31:0] sa, sb;
	logic               lt, eq;

	assign sa = in_word.operand_a;
	assign sb = in_word.operand_b;
	assign lt = sa < sb;
	assign eq = sa == sb;

	always_comb begin
		job.cls       = fxalu_pkg::CL_SIMPLE;
		job.value     = '0;
		job.flag      = 1'b0;
		job.div_zero  = 1'b0;
		job.operand_a = in_word.operand_a;
		job.operand_b = in_word.operand_b;
		case (fxalu_pkg::op_t'(in_word.cmd))
			fxalu_pkg::OP_ADD:      job.value = in_word.operand_a + in_word.operand_b;
			fxalu_pkg::OP_SUB:      job.value = in_word.operand_a - in_word.operand_b;
			fxalu_pkg::OP_MUL:      job.cls = fxalu_pkg::CL_MUL;
			fxalu_pkg::OP_DIV: begin
				if (in_word.operand_b == '0)
					job.div_zero = 1'b1;
				else
					job.cls = fxalu_pkg::CL_DIV;
			end
			fxalu_pkg::OP_GT:       job.flag = !lt && !eq;
			fxalu_pkg::OP_LT:       job.flag = lt;
			fxalu_pkg::OP_LE:       job.flag = lt || eq;
			fxalu_pkg::OP_GE:       job.flag = !lt;
			fxalu_pkg::OP_EQ:       job.flag = eq;
			fxalu_pkg::OP_NE:       job.flag = !eq;
			fxalu_pkg::OP_MIN:      job.value = lt ? in_word.operand_a : in_word.operand_b;
			fxalu_pkg::OP_MAX:      job.value = (!lt && !eq) ? in_word.operand_a
				: in_word.operand_b;
			fxalu_pkg::OP_INC:      job.value = in_word.operand_a + 32'd1;
			fxalu_pkg::OP_DEC:      job.value = in_word.operand_a - 32'd1;
			fxalu_pkg::OP_FROM_INT: job.value = in_word.operand_a << FRAC_BITS;
			fxalu_pkg::OP_TO_INT:   job.value = 32'(sa >>> FRAC_BITS);
			default:                job.value = '0;
		endcase
	end

endmodule

// ===== hw/rtl/fxalu_fifo.sv =====
// Small two-entry job queue between front and back ends.
// Depends on fxalu_pkg.
module fxalu_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fxalu_pkg::job_t    wdata,
	output logic               full,
	input  logic               pop,
	output fxalu_pkg::job_t    rdata,
	output logic               empty
);

	fxalu_pkg::job_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wp_q != rp_q)) else $error("pointers disagree with count");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("lost push");
`endif

endmodule

// ===== hw/rtl/fxalu_back.sv =====
// Back end: pipelined multiplier and radix-2 divider, 32 + FRAC_BITS + 3 stages
// with a stall-all pipeline. Depends on fxalu_pkg.
module fxalu_back #(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_v,
	input  fxalu_pkg::job_t      job,
	output logic                 out_v,
	output fxalu_pkg::out_word_t out_word
);

	localparam int NUMW = 32 + FRAC_BITS;
	localparam int DEPTH = NUMW + 2;

	// stage 1: magnitudes, plain ops pass through
	logic                 v_s1;
	fxalu_pkg::class_t    cls_s1;
	fxalu_pkg::out_word_t res_s1;
	logic [31:0]          ma_s1, mb_s1;
	logic                 neg_s1;
	logic signed [31:0]   pa_s1, pb_s1;

	logic [31:0] absa, absb;
	assign absa = job.operand_a[31] ? 32'(-job.operand_a) : job.operand_a;
	assign absb = job.operand_b[31] ? 32'(-job.operand_b) : job.operand_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1  <= job.cls;
			res_s1  <= '{value: job.value, flag: job.flag, div_zero: job.div_zero};
			ma_s1   <= absa;
			mb_s1   <= absb;
			neg_s1  <= job.operand_a[31] ^ job.operand_b[31];
			pa_s1   <= job.operand_a;
			pb_s1   <= job.operand_b;
		end
	end

	// divide chain: one quotient bit per stage; multiply product rides along
	logic                 v_d     [DEPTH];
	fxalu_pkg::class_t    cls_d   [DEPTH];
	fxalu_pkg::out_word_t res_d   [DEPTH];
	logic [NUMW-1:0]      num_d   [DEPTH];
	logic [32:0]          rem_d   [DEPTH];
	logic [31:0]          den_d   [DEPTH];
	logic                 neg_d   [DEPTH];
	logic [63:0]          prod_d  [DEPTH];

	logic signed [63:0]   prod;
	assign prod = 64'(pa_s1) * 64'(pb_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) v_d[i] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= v_s1;
			for (int i = 1; i < DEPTH; i++) v_d[i] <= v_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_d[0]  <= cls_s1;
			res_d[0]  <= res_s1;
			num_d[0]  <= NUMW'(ma_s1) << FRAC_BITS;
			rem_d[0]  <= '0;
			den_d[0]  <= mb_s1;
			neg_d[0]  <= neg_s1;
			prod_d[0] <= prod;
			for (int i = 1; i < DEPTH; i++) begin
				logic [32:0] r;
				r = {rem_d[i-1][31:0], num_d[i-1][NUMW-1]};
				cls_d[i]  <= cls_d[i-1];
				res_d[i]  <= res_d[i-1];
				den_d[i]  <= den_d[i-1];
				neg_d[i]  <= neg_d[i-1];
				prod_d[i] <= prod_d[i-1];
				if (i <= NUMW) begin
					if (r >= {1'b0, den_d[i-1]}) begin
						rem_d[i] <= r - {1'b0, den_d[i-1]};
						num_d[i] <= {num_d[i-1][NUMW-2:0], 1'b1};
					end else begin
						rem_d[i] <= r;
						num_d[i] <= {num_d[i-1][NUMW-2:0], 1'b0};
					end
				end else begin
					rem_d[i] <= rem_d[i-1];
					num_d[i] <= num_d[i-1];
				end
			end
		end
	end

	// last stage: sign the quotient, shift the product
	localparam int L = DEPTH - 1;
	logic [31:0] q;
	assign q = num_d[L][31:0];

	always_comb begin
		out_v    = v_d[L];
		out_word = res_d[L];
		case (cls_d[L])
			fxalu_pkg::CL_MUL: out_word.value = prod_d[L][FRAC_BITS +: 32];
			fxalu_pkg::CL_DIV: out_word.value = neg_d[L] ? 32'(-q) : q;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/fixed_point_alu_q24_8.sv =====
// Signed Q24.8 fixed-point ALU, queue interface on both sides.
// Path from push to result: queue, stage 1, divider chain, output register; every
// op takes the same path through the divider chain. Throughput: one word per
// cycle while pop keeps up; the bit-per-stage divide chain stalls as a whole.
// Reset: arst_n clears the queue and all valid bits; no results pending.
// Depends on fxalu_pkg, fxalu_front, fxalu_fifo, fxalu_back.
module fixed_point_alu_q24_8 #(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fxalu_pkg::in_word_t  in_word,
	output logic                 full,
	input  logic                 pop,
	output fxalu_pkg::out_word_t out_word,
	output logic                 empty
);

	fxalu_pkg::job_t job_front, job_q;
	logic            q_empty, adv, b_v;
	fxalu_pkg::out_word_t b_word;
	logic            ov_q;
	logic            ld_out;

	fxalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (.in_word(in_word), .job(job_front));

	fxalu_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(job_front), .full(full),
		.pop(adv && !q_empty), .rdata(job_q), .empty(q_empty)
	);

	// pipeline moves unless the final result is blocked
	assign adv    = !b_v || !ov_q || pop;
	assign ld_out = b_v && (!ov_q || pop);

	fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(!q_empty), .job(job_q),
		.out_v(b_v), .out_word(b_word)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (ld_out)
			ov_q <= 1'b1;
		else if (pop)
			ov_q <= 1'b0;
	end

	fxalu_pkg::out_word_t ow_q;
	always_ff @(posedge clk) begin
		if (ld_out)
			ow_q <= b_word;
	end

	assign out_word = ow_q;
	assign empty    = !ov_q;

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !pop |=> ov_q && $stable(ow_q)) else $error("result dropped");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && ow_q.div_zero |-> ow_q.value == '0 && !ow_q.flag)
		else $error("divide by zero value");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> ov_q && !pop) else $error("spurious stall");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the Q24.8 fixed-point ALU: directed table then random words,
// all results checked against table values or an in-bench predictor. Depends on fxalu_pkg and fixed_point_alu_q24_8.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 8;
	localparam int N_RANDOM = 930;
	localparam int MAX_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	fxalu_pkg::in_word_t in_word = '0;
	fxalu_pkg::out_word_t out_word;
	logic full, empty;

	fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .in_word(in_word), .full(full),
		.pop(pop), .out_word(out_word), .empty(empty)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	typedef struct {
		fxalu_pkg::in_word_t w;
		logic has_exp;
		fxalu_pkg::out_word_t exp;
	} row_t;

	fxalu_pkg::out_word_t pending_results[$];
	fxalu_pkg::in_word_t stim[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;
	bit no_idle = 0;
	bit rx_hold = 0;

	function automatic fxalu_pkg::out_word_t alu_predict(fxalu_pkg::in_word_t w);
		fxalu_pkg::out_word_t r;
		logic signed [31:0] a, b;
		logic signed [63:0] prod, da;
		logic [63:0] ma, mb, q;
		r = '0;
		a = w.operand_a;
		b = w.operand_b;
		case (fxalu_pkg::op_t'(w.cmd))
			fxalu_pkg::OP_ADD: r.value = a + b;
			fxalu_pkg::OP_SUB: r.value = a - b;
			fxalu_pkg::OP_MUL: begin
				prod = 64'(a) * 64'(b);
				prod = prod >>> FRAC;
				r.value = prod[31:0];
			end
			fxalu_pkg::OP_DIV: begin
				if (b == 0) begin
					r.div_zero = 1'b1;
				end else begin
					da = 64'(a);
					ma = (a < 0) ? 64'(-da) : 64'(da);
					mb = (b < 0) ? 64'(-64'(b)) : 64'(b);
					q = (ma << FRAC) / mb;
					if ((a < 0) != (b < 0))
						q = -q;
					r.value = q[31:0];
				end
			end
			fxalu_pkg::OP_GT: r.flag = a > b;
			fxalu_pkg::OP_LT: r.flag = a < b;
			fxalu_pkg::OP_LE: r.flag = a <= b;
			fxalu_pkg::OP_GE: r.flag = a >= b;
			fxalu_pkg::OP_EQ: r.flag = a == b;
			fxalu_pkg::OP_NE: r.flag = a != b;
			fxalu_pkg::OP_MIN: r.value = (a < b) ? a : b;
			fxalu_pkg::OP_MAX: r.value = (a > b) ? a : b;
			fxalu_pkg::OP_INC: r.value = a + 1;
			fxalu_pkg::OP_DEC: r.value = a - 1;
			fxalu_pkg::OP_FROM_INT: r.value = a << FRAC;
			default: r.value = a >>> FRAC;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return $urandom_range(0, 4) - 2;
			3: return $urandom_range(0, 4095) - 2048;
			default: return $urandom;
		endcase
	endfunction

	function automatic row_t mk(fxalu_pkg::op_t op, logic [31:0] a, logic [31:0] b,
			int has, logic [31:0] v, int f, int dz);
		row_t r;
		r.w = '{cmd: op, operand_a: a, operand_b: b};
		r.has_exp = (has != 0);
		r.exp = '{value: v, flag: (f != 0), div_zero: (dz != 0)};
		return r;
	endfunction

	row_t directed[$];

	initial begin
		row_t r;
		directed.push_back(mk(fxalu_pkg::OP_ADD, 32'h7fff_ffff, 32'd1,
			1, 32'h8000_0000, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_SUB, 32'h8000_0000, 32'd1,
			1, 32'h7fff_ffff, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_MUL, 32'h0000_0200, 32'h0000_0300,
			1, 32'h0000_0600, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000,
			0, 0, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001,
			1, 32'hffff_ffff, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_DIV, 32'h0000_0300, 32'd0,
			1, 32'd0, 0, 1));
		directed.push_back(mk(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff,
			0, 0, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_DIV, 32'hffff_ff00, 32'h0000_0300,
			0, 0, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000,
			0, 0, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_GT, 32'h7fff_ffff, 32'h8000_0000,
			1, 32'd0, 1, 0));
		directed.push_back(mk(fxalu_pkg::OP_LT, 32'h7fff_ffff, 32'h8000_0000,
			1, 32'd0, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_LE, 32'd5, 32'd5,
			1, 32'd0, 1, 0));
		directed.push_back(mk(fxalu_pkg::OP_GE, 32'hffff_ffff, 32'd0,
			1, 32'd0, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_EQ, 32'd7, 32'd7,
			1, 32'd0, 1, 0));
		directed.push_back(mk(fxalu_pkg::OP_NE, 32'd7, 32'd7,
			1, 32'd0, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_MIN, 32'h8000_0000, 32'h7fff_ffff,
			1, 32'h8000_0000, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff,
			1, 32'h7fff_ffff, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_INC, 32'h7fff_ffff, 32'hffff_ffff,
			1, 32'h8000_0000, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_DEC, 32'h8000_0000, 32'hffff_ffff,
			1, 32'h7fff_ffff, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_FROM_INT, 32'h0080_0001, 32'd0,
			1, 32'h8000_0100, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_TO_INT, 32'hffff_ff01, 32'd0,
			1, 32'hffff_ffff, 0, 0));
		directed.push_back(mk(fxalu_pkg::OP_TO_INT, 32'h7fff_ffff, 32'd0,
			1, 32'h007f_ffff, 0, 0));
		foreach (directed[i]) begin
			r = directed[i];
			stim.push_back(r.w);
			pending_results.push_back(r.has_exp ? r.exp : alu_predict(r.w));
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// sender: walks the table, then random words
	initial begin
		int n;
		fxalu_pkg::in_word_t w;
		n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (stim.size() != 0 || n < N_RANDOM) begin
			if (stim.size() == 0) begin
				w.cmd = 4'($urandom_range(0, 15));
				w.operand_a = rand_operand();
				w.operand_b = rand_operand();
				stim.push_back(w);
				pending_results.push_back(alu_predict(w));
				n++;
			end
			if (!no_idle && $urandom_range(0, 99) < 25) begin
				push <= 1'b0;
				@(posedge clk);
			end else begin
				push <= 1'b1;
				in_word <= stim[0];
				@(posedge clk);
				while (full) @(posedge clk);
				void'(stim.pop_front());
			end
			if (n == 300) no_idle = 1;
			if (n == 450) no_idle = 0;
			if (n == 600) rx_hold = 1;
		end
		push <= 1'b0;
		stim_done = 1;
	end

	// receiver, with one long hold-off
	initial begin
		int held;
		held = 0;
		forever begin
			if (rx_hold && held < 300) begin
				pop <= 1'b0;
				held++;
			end else if (!no_idle && $urandom_range(0, 99) < 25) begin
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $realtime, out_word);
				end else begin
					if (out_word.value !== pending_results[0].value) begin
						errors++;
						$display("%0t: value exp %h got %h", $realtime,
							pending_results[0].value, out_word.value);
					end
					if (out_word.flag !== pending_results[0].flag) begin
						errors++;
						$display("%0t: flag exp %b got %b", $realtime,
							pending_results[0].flag, out_word.flag);
					end
					if (out_word.div_zero !== pending_results[0].div_zero) begin
						errors++;
						$display("%0t: div_zero exp %b got %b", $realtime,
							pending_results[0].div_zero, out_word.div_zero);
					end
					void'(pending_results.pop_front());
				end
			end
		end
	end

	initial begin
		wait (stim_done && pending_results.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
